// ----- design/shbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Round constants, initial chaining value, round helper functions and the
// command word passed from the front end to the compression engine.
// ----------------------------------------------------------------------------
package shbs_pkg;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    typedef logic [31:0] word_t;

    // one classified input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD_MSG,
        ST_SCHED,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_START,
        ST_PAD_FILL,
        ST_EMIT
    } eng_state_t;

    localparam logic [255:0] InitChain = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte    = 8'h80;
    localparam logic [5:0] LengthSlot = 6'd56;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        unique case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ----- design/sha256_byte_stream_hasher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Channel | signals                                        | direction
// input   | in_valid, in_stall, data_byte, byte_present,   | into block
//         | end_of_message                                 |
// output  | out_valid, out_stall, digest_word, word_index, | out of block
//         | last_word                                      |
// A byte is taken only while the engine is idle; a full block is then loaded
// as 16 words, runs 64 rounds on the single shared round unit and updates.
// End of message adds a set-up state and one or two padding compressions,
// then eight output transfers that out_stall can hold.
// A four-entry queue decouples the input; in_stall is high while it is full.
// Reset restores the initial chaining value, empty buffer and zero length.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import shbs_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    shbs_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .cmd_valid      (cmd_valid),
        .cmd_take       (cmd_take),
        .cmd            (cmd)
    );

    shbs_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

// ----- design/shbs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts input transfers, drops items that carry neither flag and queues
// the rest for the compression engine.
// ----------------------------------------------------------------------------
module shbs_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              byte_present,
    input  logic              end_of_message,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output shbs_pkg::cmd_t    cmd
);
    import shbs_pkg::*;

    cmd_t               fifo_mem [QueueDepth];
    logic [QueueAw-1:0] wr_ptr_reg;
    logic [QueueAw-1:0] wr_ptr_next;
    logic [QueueAw-1:0] rd_ptr_reg;
    logic [QueueAw-1:0] rd_ptr_next;
    logic [QueueAw:0]   count_reg;
    logic [QueueAw:0]   count_next;
    logic               push;
    logic               pop;

    assign in_stall  = (count_reg == (QueueAw+1)'(QueueDepth));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_mem[rd_ptr_reg];

    // items with neither flag are consumed here and never queued
    assign push = in_valid && !in_stall && (byte_present || end_of_message);
    assign pop  = cmd_valid && cmd_take;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{data_byte, byte_present, end_of_message};
        end
    end

endmodule

// ----- design/shbs_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Buffers bytes into 64-byte blocks, pads at end of message, runs one
// round per cycle and streams out the eight digest words.
// ----------------------------------------------------------------------------
module shbs_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_take,
    input  shbs_pkg::cmd_t    cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word
);
    import shbs_pkg::*;

    // block buffer as 16 big-endian words, written a byte at a time;
    // one registered word read per cycle, prefetched one word ahead
    logic [31:0]  buf_mem [16];

    eng_state_t   state_reg;
    eng_state_t   state_next;
    logic [5:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [255:0] chain_reg;
    logic [255:0] work_reg;
    logic [511:0] sched_reg;       // sliding window of 16 schedule words
    logic [5:0]   cnt_reg;         // word index while loading / round index
    logic         pad_final_reg;   // current compression is the last one
    logic         pad_second_reg;  // a second padding block is pending
    logic [5:0]   pad_fill_reg;    // fill level at end of message
    logic [2:0]   out_idx_reg;
    logic [31:0]  buf_rd_reg;
    logic [3:0]   rd_addr;
    logic [31:0]  buf_word;
    logic [31:0]  pad_word;
    logic [31:0]  w_new;
    logic [31:0]  w_cur;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [255:0] chain_sum;
    logic         take_byte;
    logic         full_now;

    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;
    assign take_byte = cmd_take && cmd.byte_present;
    assign full_now  = take_byte && (fill_reg == 6'd63);

    assign out_valid   = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[255 - 32*out_idx_reg -: 32];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    // word 0 is fetched in the cycle before loading starts
    assign rd_addr  = (state_reg == ST_LOAD_MSG || state_reg == ST_PAD_FILL)
                    ? cnt_reg[3:0] + 4'd1 : 4'd0;
    assign buf_word = buf_rd_reg;

    // padding word at word slot cnt_reg[3:0] of the current padding block
    always_comb
    begin
        logic [7:0] b [4];
        logic [5:0] pos;
        for (int i = 0; i < 4; i++)
        begin
            pos = {cnt_reg[3:0], 2'(i)};
            // final block: length at the end; second of two blocks: zeros before it
            if (pad_final_reg && pos >= LengthSlot)
                b[i] = len_reg[63 - 8*(pos - LengthSlot) -: 8];
            else if (pos < pad_fill_reg && !(pad_final_reg && pad_fill_reg >= LengthSlot))
                b[i] = buf_rd_reg[31 - 8*i -: 8];
            else if (pos == pad_fill_reg && !(pad_final_reg && pad_fill_reg >= LengthSlot))
                b[i] = PadByte;
            else
                b[i] = 8'h00;
        end
        pad_word = {b[0], b[1], b[2], b[3]};
    end

    assign w_cur = sched_reg[511 -: 32];
    assign w_new = ssig1(sched_reg[63:32]) + sched_reg[223:192]
                 + ssig0(sched_reg[479:448]) + sched_reg[511:480];

    assign t1 = work_reg[31:0] + bsig1(work_reg[127:96])
              + ((work_reg[127:96] & work_reg[95:64]) ^ (~work_reg[127:96] & work_reg[63:32]))
              + round_k(cnt_reg) + w_cur;
    assign t2 = bsig0(work_reg[255:224])
              + ((work_reg[255:224] & work_reg[223:192]) ^ (work_reg[255:224] & work_reg[191:160])
                 ^ (work_reg[223:192] & work_reg[191:160]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_sum[255 - 32*i -: 32] = chain_reg[255 - 32*i -: 32] + work_reg[255 - 32*i -: 32];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    if (full_now)
                        state_next = ST_LOAD_MSG;
                    else if (cmd.end_of_message)
                        state_next = ST_PAD_START;
                end
            end
            ST_LOAD_MSG:  state_next = (cnt_reg == 6'd15) ? ST_ROUND : ST_LOAD_MSG;
            ST_PAD_START: state_next = ST_PAD_FILL;
            ST_PAD_FILL:  state_next = (cnt_reg == 6'd15) ? ST_ROUND : ST_PAD_FILL;
            ST_SCHED:     state_next = ST_ROUND;
            ST_ROUND:     state_next = (cnt_reg == 6'd63) ? ST_UPDATE : ST_ROUND;
            ST_UPDATE:
            begin
                if (pad_second_reg)
                    state_next = ST_PAD_FILL;
                else if (pad_final_reg)
                    state_next = ST_EMIT;
                else if (pad_fill_reg != 6'd0)
                    state_next = ST_PAD_START;   // end of message right after a full block
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_stall && out_idx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_byte)
        begin
            buf_mem[fill_reg[5:2]][31 - 8*fill_reg[1:0] -: 8] <= cmd.data_byte;
        end
        buf_rd_reg <= buf_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            len_reg        <= '0;
            chain_reg      <= InitChain;
            cnt_reg        <= '0;
            pad_final_reg  <= 1'b0;
            pad_second_reg <= 1'b0;
            pad_fill_reg   <= '0;
            out_idx_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (take_byte)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        len_reg  <= len_reg + 64'd8;
                    end
                    // pad_fill_reg != 0 marks a pending end after a full block;
                    // an empty tail uses the padding path from ST_PAD_START
                    pad_fill_reg <= (full_now && cmd.end_of_message) ? 6'd1 : 6'd0;
                    pad_final_reg  <= 1'b0;
                    pad_second_reg <= 1'b0;
                end
                ST_LOAD_MSG:
                begin
                    sched_reg <= {sched_reg[479:0], buf_word};
                    cnt_reg   <= (cnt_reg == 6'd15) ? 6'd0 : cnt_reg + 6'd1;
                    work_reg  <= chain_reg;
                end
                ST_PAD_START:
                begin
                    cnt_reg        <= '0;
                    pad_fill_reg   <= fill_reg;
                    pad_final_reg  <= (fill_reg < LengthSlot);
                    pad_second_reg <= (fill_reg >= LengthSlot);
                end
                ST_PAD_FILL:
                begin
                    sched_reg <= {sched_reg[479:0], pad_word};
                    cnt_reg   <= (cnt_reg == 6'd15) ? 6'd0 : cnt_reg + 6'd1;
                    work_reg  <= chain_reg;
                end
                ST_ROUND:
                begin
                    work_reg  <= {t1 + t2, work_reg[255:160], work_reg[159:128] + t1,
                                  work_reg[127:32]};
                    sched_reg <= {sched_reg[479:0], w_new};
                    cnt_reg   <= cnt_reg + 6'd1;
                end
                ST_UPDATE:
                begin
                    chain_reg <= chain_sum;
                    cnt_reg   <= '0;
                    if (pad_second_reg)
                    begin
                        // second block: zeros then length
                        pad_second_reg <= 1'b0;
                        pad_final_reg  <= 1'b1;
                        pad_fill_reg   <= LengthSlot;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            chain_reg <= InitChain;
                            fill_reg  <= '0;
                            len_reg   <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- tb/sha256_byte_stream_hasher_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds byte items (with finish-only and empty-item cases) through random
// idling on both channels. A behavioural SHA-256 in the bench predicts the
// eight digest words of each finished message, checked in order.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core_tb;
    import shbs_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    localparam int StallLimit = 20000;
    localparam int TailCycles = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    sha256_byte_stream_hasher_core uut (.*);

    byte_item_t  pending_items[$];
    digest_out_t digest_queue[$];
    int          fail_count;
    int          idle_cycles;
    bit          calm;
    bit          hold_off;

    // predictor state
    logic [31:0] hv[8];
    logic [7:0]  blk[64];
    int          nbytes;
    logic [63:0] bitlen;

    logic [31:0] kt[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block(input logic [7:0] b[64]);
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = {b[4*t], b[4*t+1], b[4*t+2], b[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        v = hv;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kt[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hv[i] = hv[i] + v[i];
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
            hv[i] = InitChain[255 - 32*i -: 32];
        nbytes = 0;
        bitlen = '0;
    endtask

    task automatic predict_digest(input byte_item_t it);
        logic [7:0] fin[64];
        digest_out_t d;
        if (it.byte_present)
        begin
            blk[nbytes] = it.data_byte;
            nbytes++;
            bitlen += 64'd8;
            if (nbytes == 64)
            begin
                compress_block(blk);
                nbytes = 0;
            end
        end
        if (it.end_of_message)
        begin
            for (int i = 0; i < 64; i++)
                fin[i] = (i < nbytes) ? blk[i] : 8'h00;
            fin[nbytes] = PadByte;
            if (nbytes >= LengthSlot)
            begin
                compress_block(fin);
                for (int i = 0; i < 64; i++)
                    fin[i] = 8'h00;
            end
            for (int j = 0; j < 8; j++)
                fin[56 + j] = bitlen[63 - 8*j -: 8];
            compress_block(fin);
            for (int j = 0; j < 8; j++)
            begin
                d.digest_word = hv[j];
                d.word_index  = j[2:0];
                d.last_word   = (j == 7);
                digest_queue.push_back(d);
            end
            restart_hash();
        end
    endtask

    task automatic add_message(input int len, input bit tail_flag_only);
        byte_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.data_byte      = 8'($urandom_range(0, 255));
            it.byte_present   = 1'b1;
            it.end_of_message = (!tail_flag_only && i == len - 1);
            pending_items.push_back(it);
        end
        if (tail_flag_only || len == 0)
        begin
            it.data_byte      = 8'($urandom_range(0, 255));
            it.byte_present   = 1'b0;
            it.end_of_message = 1'b1;
            pending_items.push_back(it);
        end
    endtask

    always
    begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            data_byte      <= '0;
            byte_present   <= 1'b0;
            end_of_message <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                predict_digest({data_byte, byte_present, end_of_message});
            if (pending_items.size() > 0 && !hold_off && (calm || $urandom_range(0, 99) >= 30))
            begin
                {data_byte, byte_present, end_of_message} <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        digest_out_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest word %h", digest_word);
                    fail_count++;
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (digest_word !== want.digest_word)
                    begin
                        $error("digest_word exp %h got %h", want.digest_word, digest_word);
                        fail_count++;
                    end
                    if (word_index !== want.word_index)
                    begin
                        $error("word_index exp %0d got %0d", want.word_index, word_index);
                        fail_count++;
                    end
                    if (last_word !== want.last_word)
                    begin
                        $error("last_word exp %0d got %0d", want.last_word, last_word);
                        fail_count++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 30);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        byte_item_t it;
        int n;
        fail_count = 0;
        idle_cycles = 0;
        calm = 0;
        hold_off = 0;
        out_stall = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        byte_present = 1'b0;
        end_of_message = 1'b0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        restart_hash();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, idle item, extreme bytes, finish-only items
        add_message(0, 1'b0);
        it = '{8'hff, 1'b0, 1'b0};
        pending_items.push_back(it);
        it = '{8'h00, 1'b1, 1'b0};
        pending_items.push_back(it);
        it = '{8'hff, 1'b1, 1'b1};
        pending_items.push_back(it);
        it = '{8'h61, 1'b1, 1'b0};
        pending_items.push_back(it);
        it = '{8'h00, 1'b0, 1'b1};
        pending_items.push_back(it);
        add_message(3, 1'b0);
        add_message(5, 1'b1);

        // let everything drain before the next part
        while (pending_items.size() > 0 || in_valid || digest_queue.size() > 0)
            @(posedge clk);
        hold_off = 1;
        repeat (20) @(posedge clk);
        hold_off = 0;

        // lengths around 55/56/63/64 exercise the one/two block padding split
        add_message(55, 1'b0);
        add_message(56, 1'b0);
        add_message(63, 1'b1);
        add_message(64, 1'b0);
        calm = 1;
        while (pending_items.size() > 0)
            @(posedge clk);
        calm = 0;
        while (pending_items.size() < 120)
        begin
            n = $urandom_range(0, 9);
            if (n == 0)
            begin
                it.data_byte = 8'($urandom_range(0, 255));
                it.byte_present = 1'b0;
                it.end_of_message = 1'b0;
                pending_items.push_back(it);
            end
            else
                add_message($urandom_range(0, 20), $urandom_range(0, 3) == 0);
        end
        while (pending_items.size() > 0 || in_valid)
            @(posedge clk);
        while (digest_queue.size() > 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0 && digest_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
design/shbs_pkg.sv
design/shbs_front.sv
design/shbs_engine.sv
design/sha256_byte_stream_hasher_core.sv
tb/sha256_byte_stream_hasher_core_tb.sv
